/* sv/assert_macros.svh */
// ---------------------------------------------------------------------------
// Assertion macros
// Shorthand for the concurrent checks used by the checker module.
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked check, switched off while reset is held
`define ASSERT_CLK(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Clocked check that also holds while reset is held
`define ASSERT_ALWAYS(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) (prop)) else $error(msg);

`endif

/* sv/slme_pkg.sv */
// ---------------------------------------------------------------------------
// slme_pkg
// Shared types and constants of the sorted list merge engine.
// ---------------------------------------------------------------------------
package slme_pkg;

    // Default sizes
    localparam int DEF_LIST_DEPTH = 32;
    localparam int DEF_VALUE_BITS = 32;

    // Fixed field widths on the stream ports
    localparam int DATA_BITS     = 32;
    localparam int IN_USER_BITS  = 2;
    localparam int OUT_USER_BITS = 2;

    // Request opcodes (carried on s_tuser)
    localparam logic [IN_USER_BITS-1:0] OP_LOAD_FIRST  = 2'd0;
    localparam logic [IN_USER_BITS-1:0] OP_LOAD_SECOND = 2'd1;
    localparam logic [IN_USER_BITS-1:0] OP_MERGE       = 2'd2;
    localparam logic [IN_USER_BITS-1:0] OP_CLEAR       = 2'd3;

    // Bit positions in m_tuser
    localparam int USER_FROM_SECOND = 0;
    localparam int USER_OVERFLOW    = 1;

    // Controller states
    typedef enum logic
    {
        ST_IDLE,
        ST_MERGE
    } state_t;

    // Decision of the head comparator for one merge step
    typedef struct packed
    {
        logic take_second;
        logic last;
    } pick_t;

endpackage

/* sv/slme_ram.sv */
// ---------------------------------------------------------------------------
// slme_ram
// Simple dual-port RAM: one write port, one read port, registered read.
// ---------------------------------------------------------------------------
module slme_ram #(
    parameter int WIDTH = slme_pkg::DEF_VALUE_BITS,
    parameter int DEPTH = slme_pkg::DEF_LIST_DEPTH,
    localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             clk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // Write port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    // Registered read port
    always_ff @(posedge clk)
    begin
        rdata <= mem[raddr];
    end

endmodule

/* sv/slme_pick.sv */
// ---------------------------------------------------------------------------
// slme_pick
// Head comparator: picks the list that supplies the next merged element and
// flags the final element of the run.
// ---------------------------------------------------------------------------
module slme_pick #(
    parameter int VALUE_BITS = slme_pkg::DEF_VALUE_BITS,
    parameter int LIST_DEPTH = slme_pkg::DEF_LIST_DEPTH,
    localparam int CW        = $clog2(LIST_DEPTH + 1)
) (
    input  logic [VALUE_BITS-1:0]          first_head,
    input  logic [VALUE_BITS-1:0]          second_head,
    input  logic [CW-1:0]                  first_idx,
    input  logic [CW-1:0]                  second_idx,
    input  logic [CW-1:0]                  first_count,
    input  logic [CW-1:0]                  second_count,
    output slme_pkg::pick_t                pick,
    output logic [slme_pkg::DATA_BITS-1:0] head_out
);

    localparam int EXT_BITS = (VALUE_BITS > slme_pkg::DATA_BITS) ?
                              VALUE_BITS : slme_pkg::DATA_BITS;

    logic                         first_more;
    logic                         second_more;
    logic                         first_less;
    logic [CW:0]                  taken_plus_one;
    logic [CW:0]                  total;
    logic signed [VALUE_BITS-1:0] chosen_s;
    logic signed [EXT_BITS-1:0]   chosen_ext;

    // Which lists still hold elements
    assign first_more  = (first_idx < first_count);
    assign second_more = (second_idx < second_count);

    // Signed compare; ties go to the second list
    assign first_less = ($signed(first_head) < $signed(second_head));

    assign pick.take_second = (first_more && second_more) ? !first_less : !first_more;

    // Last element when only one remains in total
    assign taken_plus_one = (CW + 1)'(first_idx) + (CW + 1)'(second_idx) + (CW + 1)'(1);
    assign total          = (CW + 1)'(first_count) + (CW + 1)'(second_count);
    assign pick.last      = (taken_plus_one == total);

    // Low 32 bits of the sign-extended element
    assign chosen_s   = pick.take_second ? second_head : first_head;
    assign chosen_ext = EXT_BITS'(chosen_s);
    assign head_out   = chosen_ext[slme_pkg::DATA_BITS-1:0];

endmodule

/* sv/sorted_list_merge_engine.sv */
// ---------------------------------------------------------------------------
// sorted_list_merge_engine
// Holds two lists of signed values in RAM and merges them into one
// ascending result stream on request.
// ---------------------------------------------------------------------------
//  Channel  | Signals                          | Content
//  ---------+----------------------------------+------------------------------
//  input    | s_tvalid s_tready s_tdata s_tuser| value, opcode
//  output   | m_tvalid m_tready m_tdata m_tuser| merged_value, from_second,
//           | m_tlast                          | overflow, last_item
//
//  Load and clear requests leave the engine idle; a load into a full list
//  returns one overflow result.
//  A merge first reads both list heads from RAM, then sends one element per
//  cycle from the head comparator while the output can take it.
//  A new request is taken only in idle with the output register free or
//  being emptied; output stalls hold the merge pointers in place.
//  Reset empties both lists; the RAMs keep their contents.
// ---------------------------------------------------------------------------
module sorted_list_merge_engine #(
    parameter int LIST_DEPTH = slme_pkg::DEF_LIST_DEPTH,
    parameter int VALUE_BITS = slme_pkg::DEF_VALUE_BITS
) (
    input  logic                               clk,
    input  logic                               rst_n,
    // input requests
    input  logic                               s_tvalid,
    output logic                               s_tready,
    input  logic [slme_pkg::DATA_BITS-1:0]     s_tdata,   // [31:0] value
    input  logic [slme_pkg::IN_USER_BITS-1:0]  s_tuser,   // [1:0] opcode
    // merged results
    output logic                               m_tvalid,
    input  logic                               m_tready,
    output logic [slme_pkg::DATA_BITS-1:0]     m_tdata,   // [31:0] merged_value
    output logic [slme_pkg::OUT_USER_BITS-1:0] m_tuser,   // [0] from_second, [1] overflow
    output logic                               m_tlast    // last_item
);

    localparam int AW       = (LIST_DEPTH > 1) ? $clog2(LIST_DEPTH) : 1;
    localparam int CW       = $clog2(LIST_DEPTH + 1);
    localparam int EXT_BITS = (VALUE_BITS > slme_pkg::DATA_BITS) ?
                              VALUE_BITS : slme_pkg::DATA_BITS;

    slme_pkg::state_t state_reg, state_next;

    logic [CW-1:0] first_count_reg, first_count_next;
    logic [CW-1:0] second_count_reg, second_count_next;
    logic [CW-1:0] first_idx_reg, first_idx_next;
    logic [CW-1:0] second_idx_reg, second_idx_next;

    logic                                m_valid_reg, m_valid_next;
    logic [slme_pkg::DATA_BITS-1:0]      m_data_reg, m_data_next;
    logic [slme_pkg::OUT_USER_BITS-1:0]  m_user_reg, m_user_next;
    logic                                m_last_reg, m_last_next;

    logic                         out_free;
    logic                         accept;
    logic                         first_full;
    logic                         second_full;
    logic                         first_we;
    logic                         second_we;
    logic signed [slme_pkg::DATA_BITS-1:0] value_s;
    logic signed [EXT_BITS-1:0]   value_ext;
    logic [VALUE_BITS-1:0]        store_value;
    logic [VALUE_BITS-1:0]        first_head;
    logic [VALUE_BITS-1:0]        second_head;
    slme_pkg::pick_t              pick;
    logic [slme_pkg::DATA_BITS-1:0] head_out;

    // Handshake
    assign out_free = !m_valid_reg || m_tready;
    assign s_tready = (state_reg == slme_pkg::ST_IDLE) && out_free;
    assign accept   = s_tvalid && s_tready;

    assign first_full  = (first_count_reg == CW'(LIST_DEPTH));
    assign second_full = (second_count_reg == CW'(LIST_DEPTH));

    // Incoming value wrapped to the stored width
    assign value_s     = s_tdata;
    assign value_ext   = EXT_BITS'(value_s);
    assign store_value = value_ext[VALUE_BITS-1:0];

    assign first_we  = accept && (s_tuser == slme_pkg::OP_LOAD_FIRST) && !first_full;
    assign second_we = accept && (s_tuser == slme_pkg::OP_LOAD_SECOND) && !second_full;

    // List storage; the read address follows the next pointers
    slme_ram #(
        .WIDTH (VALUE_BITS),
        .DEPTH (LIST_DEPTH)
    ) u_first_ram (
        .clk   (clk),
        .we    (first_we),
        .waddr (first_count_reg[AW-1:0]),
        .wdata (store_value),
        .raddr (first_idx_next[AW-1:0]),
        .rdata (first_head)
    );

    slme_ram #(
        .WIDTH (VALUE_BITS),
        .DEPTH (LIST_DEPTH)
    ) u_second_ram (
        .clk   (clk),
        .we    (second_we),
        .waddr (second_count_reg[AW-1:0]),
        .wdata (store_value),
        .raddr (second_idx_next[AW-1:0]),
        .rdata (second_head)
    );

    // Head comparison
    slme_pick #(
        .VALUE_BITS (VALUE_BITS),
        .LIST_DEPTH (LIST_DEPTH)
    ) u_pick (
        .first_head   (first_head),
        .second_head  (second_head),
        .first_idx    (first_idx_reg),
        .second_idx   (second_idx_reg),
        .first_count  (first_count_reg),
        .second_count (second_count_reg),
        .pick         (pick),
        .head_out     (head_out)
    );

    // Controller: next state, pointers, counts and output register
    always_comb
    begin
        state_next        = state_reg;
        first_count_next  = first_count_reg;
        second_count_next = second_count_reg;
        first_idx_next    = first_idx_reg;
        second_idx_next   = second_idx_reg;
        m_valid_next      = m_valid_reg && !m_tready;
        m_data_next       = m_data_reg;
        m_user_next       = m_user_reg;
        m_last_next       = m_last_reg;

        unique case (state_reg)
            slme_pkg::ST_IDLE:
            begin
                if (accept)
                begin
                    unique case (s_tuser)
                        slme_pkg::OP_LOAD_FIRST:
                        begin
                            if (first_full)
                            begin
                                m_valid_next = 1'b1;
                                m_data_next  = '0;
                                m_user_next  = '0;
                                m_user_next[slme_pkg::USER_OVERFLOW] = 1'b1;
                                m_last_next  = 1'b0;
                            end
                            else
                            begin
                                first_count_next = first_count_reg + CW'(1);
                            end
                        end
                        slme_pkg::OP_LOAD_SECOND:
                        begin
                            if (second_full)
                            begin
                                m_valid_next = 1'b1;
                                m_data_next  = '0;
                                m_user_next  = '0;
                                m_user_next[slme_pkg::USER_OVERFLOW] = 1'b1;
                                m_last_next  = 1'b0;
                            end
                            else
                            begin
                                second_count_next = second_count_reg + CW'(1);
                            end
                        end
                        slme_pkg::OP_MERGE:
                        begin
                            // Present address zero now so the heads are ready next cycle
                            first_idx_next  = '0;
                            second_idx_next = '0;
                            if ((first_count_reg != '0) || (second_count_reg != '0))
                            begin
                                state_next = slme_pkg::ST_MERGE;
                            end
                        end
                        slme_pkg::OP_CLEAR:
                        begin
                            first_count_next  = '0;
                            second_count_next = '0;
                        end
                        default:
                        begin
                        end
                    endcase
                end
            end

            slme_pkg::ST_MERGE:
            begin
                // One element per cycle while the output can take it
                if (out_free)
                begin
                    m_valid_next = 1'b1;
                    m_data_next  = head_out;
                    m_user_next  = '0;
                    m_user_next[slme_pkg::USER_FROM_SECOND] = pick.take_second;
                    m_last_next  = pick.last;
                    if (pick.take_second)
                    begin
                        second_idx_next = second_idx_reg + CW'(1);
                    end
                    else
                    begin
                        first_idx_next = first_idx_reg + CW'(1);
                    end
                    if (pick.last)
                    begin
                        state_next = slme_pkg::ST_IDLE;
                    end
                end
            end

            default:
            begin
                state_next = slme_pkg::ST_IDLE;
            end
        endcase
    end

    // Control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= slme_pkg::ST_IDLE;
            first_count_reg  <= '0;
            second_count_reg <= '0;
            first_idx_reg    <= '0;
            second_idx_reg   <= '0;
            m_valid_reg      <= 1'b0;
        end
        else
        begin
            state_reg        <= state_next;
            first_count_reg  <= first_count_next;
            second_count_reg <= second_count_next;
            first_idx_reg    <= first_idx_next;
            second_idx_reg   <= second_idx_next;
            m_valid_reg      <= m_valid_next;
        end
    end

    // Output payload
    always_ff @(posedge clk)
    begin
        m_data_reg <= m_data_next;
        m_user_reg <= m_user_next;
        m_last_reg <= m_last_next;
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = m_data_reg;
    assign m_tuser  = m_user_reg;
    assign m_tlast  = m_last_reg;

endmodule

/* sv/slme_checker.sv */
// ---------------------------------------------------------------------------
// slme_checker
// Port-level checks on the merge engine, bound to the top level.
// ---------------------------------------------------------------------------
`include "assert_macros.svh"

module slme_checker (
    input logic                               clk,
    input logic                               rst_n,
    input logic                               s_tready,
    input logic                               m_tvalid,
    input logic                               m_tready,
    input logic [slme_pkg::DATA_BITS-1:0]     m_tdata,
    input logic [slme_pkg::OUT_USER_BITS-1:0] m_tuser,
    input logic                               m_tlast
);

    // A stalled result holds
    `ASSERT_CLK(a_out_hold, m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser) && $stable(m_tlast), "stalled result changed")

    // An overflow result carries nothing else
    `ASSERT_CLK(a_ovf_clean, m_tvalid && m_tuser[slme_pkg::USER_OVERFLOW] |-> m_tdata == '0 && !m_tuser[slme_pkg::USER_FROM_SECOND] && !m_tlast, "overflow result with payload")

    // Requests are taken only when a result could be placed
    `ASSERT_CLK(a_in_room, s_tready |-> !m_tvalid || m_tready, "request taken with output blocked")

    // No result once a reset edge has been seen
    `ASSERT_ALWAYS(a_rst_quiet, !rst_n |=> !m_tvalid, "result shown in reset")

endmodule

bind sorted_list_merge_engine slme_checker u_slme_checker (.*);
